// ===== hdl/bpa_pkg.sv =====
// Package for the battery pack aggregator: constants, config indexes, status ranking.
package bpa_pkg;

	localparam int PackCountDefault = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] CFG_FAULT = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_UPDATING = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_STANDBY = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_INACTIVE = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_DARKSTART = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_ACTIVE = 3'd5;

	typedef struct packed {
		logic [7:0] fault;
		logic [7:0] updating;
		logic [7:0] standby;
		logic [7:0] inactive;
		logic [7:0] darkstart;
		logic [7:0] active;
	} codes_t;

	// priority of a status code, first match wins
	function automatic logic [2:0] status_rank(input logic [7:0] c, input codes_t k);
		logic [2:0] r;
		if (c == k.fault) r = 3'd5;
		else if (c == k.updating) r = 3'd4;
		else if (c == k.standby) r = 3'd3;
		else if (c == k.inactive) r = 3'd2;
		else if (c == k.darkstart) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

endpackage

// ===== hdl/bpa_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module bpa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [50:0] dividend,
	input  logic [34:0] divisor,
	output logic        done,
	output logic [50:0] quotient
);
	logic [35:0] rem_q;
	logic [50:0] quo_q;
	logic [34:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [35:0] trial;
	logic [35:0] shifted;

	assign shifted = {rem_q[34:0], quo_q[50]};
	assign trial = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;

	// one shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd51;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[35]) begin
				rem_q <= trial;
				quo_q <= {quo_q[49:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[49:0], 1'b0};
			end
		end
	end
endmodule

// ===== hdl/battery_pack_aggregator_top.sv =====
// Top level of the battery pack aggregator: accumulators, sequencer, shared divider.
//
// Usage: drive the four frames with pack_alive and last_pack and pulse start
// while busy is low; the transaction is taken at that edge. An alive pack is
// folded into the running state, up to PACK_COUNT packs: the soc times capacity
// product goes through a 16x32 multiplier, registered, then added. busy stays
// high through the MUL and ADD states, so a new pack is taken only after the
// sequencer returns to idle. On last_pack, after the fold, the shared restoring
// divider computes voltage average, then weighted state of charge; the charge
// and discharge limit products reuse the multiplier. The result appears on the
// result ports with done high for one cycle; the receiver cannot stall it.
// Accumulators then clear for the next set. Configuration writes (cfg_we,
// cfg_index, cfg_data) set the status codes and are taken at once.
// Reset clears the codes to their defaults and all accumulators; the first
// transaction may start in the cycle after reset is released.
module battery_pack_aggregator_top #(
	parameter int PACK_COUNT = bpa_pkg::PackCountDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [63:0]                 live_frame,
	input  logic [63:0]                 limits_frame,
	input  logic [63:0]                 health_frame,
	input  logic [63:0]                 energy_frame,
	input  logic                        pack_alive,
	input  logic                        last_pack,
	input  logic                        cfg_we,
	input  logic [bpa_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bpa_pkg::CfgDataW-1:0] cfg_data,
	output logic                        done,
	output logic [3:0]                  alive_count,
	output logic [15:0]                 voltage_average,
	output logic [15:0]                 voltage_highest,
	output logic [15:0]                 voltage_lowest,
	output logic signed [18:0]          current_total,
	output logic [15:0]                 charge_state,
	output logic [63:0]                 limits_result,
	output logic [63:0]                 health_result,
	output logic [31:0]                 capacity_total,
	output logic [31:0]                 capacity_remaining
);
	import bpa_pkg::*;

	localparam int TallyW = $clog2(PACK_COUNT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DIVV = 3'd3;
	localparam logic [2:0] ST_DIVS = 3'd4;
	localparam logic [2:0] ST_LIMC = 3'd5;
	localparam logic [2:0] ST_LIMD = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	codes_t codes_q;

	// captured item
	logic [63:0] lf_q, mf_q, hf_q, ef_q;
	logic        alive_q, last_q;

	// accumulators
	logic [TallyW-1:0] tally_q;
	logic [18:0] vsum_q;
	logic [15:0] vmax_q, vmin_q;
	logic signed [18:0] isum_q;
	logic [50:0] socsum_q;
	logic [34:0] capw_q;
	logic [31:0] capt_q, capr_q;
	logic [15:0] chmin_q, dsmin_q;
	logic        chz_q, dsz_q;
	logic [15:0] cellh_q, celll_q;
	logic signed [15:0] temph_q, templ_q;
	logic [15:0] soh_q;
	logic [7:0]  worst_q, bal_q;
	logic        div_wait_q;

	// shared multiplier, registered product
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] prod_q;

	logic        div_go;
	logic [50:0] div_n;
	logic [34:0] div_d;
	logic        div_done;
	logic [50:0] div_quo;
	logic        take;

	assign busy = (state_q != ST_IDLE);
	assign take = alive_q && ({{(32-TallyW){1'b0}}, tally_q} < PACK_COUNT);

	bpa_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_n), .divisor(div_d),
		.done(div_done), .quotient(div_quo)
	);

	// multiplier operand select
	always_comb begin
		mul_a = ef_q[31:0];
		mul_b = lf_q[47:32];
		if (state_q == ST_LIMC) mul_a = {16'd0, chmin_q};
		else if (state_q == ST_LIMD) mul_a = {16'd0, dsmin_q};
		if (state_q == ST_LIMC || state_q == ST_LIMD)
			mul_b = {{(16-TallyW){1'b0}}, tally_q};
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divider operand select
	always_comb begin
		div_go = 1'b0;
		div_n = {32'd0, vsum_q};
		div_d = {{(35-TallyW){1'b0}}, tally_q};
		if (state_q == ST_DIVV && div_wait_q) begin
			div_go = 1'b1;
		end else if (state_q == ST_DIVV && div_done) begin
			div_go = 1'b1;
			div_n = socsum_q;
			div_d = capw_q;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '{8'd4, 8'd5, 8'd0, 8'd1, 8'd2, 8'd3};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FAULT:     codes_q.fault <= cfg_data;
				CFG_UPDATING:  codes_q.updating <= cfg_data;
				CFG_STANDBY:   codes_q.standby <= cfg_data;
				CFG_INACTIVE:  codes_q.inactive <= cfg_data;
				CFG_DARKSTART: codes_q.darkstart <= cfg_data;
				CFG_ACTIVE:    codes_q.active <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			lf_q <= live_frame;
			mf_q <= limits_frame;
			hf_q <= health_frame;
			ef_q <= energy_frame;
			alive_q <= pack_alive;
			last_q <= last_pack;
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			div_wait_q <= 1'b0;
			tally_q <= '0; vsum_q <= '0; vmax_q <= '0; vmin_q <= '1;
			isum_q <= '0; socsum_q <= '0; capw_q <= '0; capt_q <= '0; capr_q <= '0;
			chmin_q <= '1; dsmin_q <= '1; chz_q <= 1'b0; dsz_q <= 1'b0;
			cellh_q <= '0; celll_q <= '1; temph_q <= 16'sh8000; templ_q <= 16'sh7fff;
			soh_q <= '1; worst_q <= 8'd3; bal_q <= '0;
			alive_count <= '0; voltage_average <= '0; voltage_highest <= '0;
			voltage_lowest <= '0; current_total <= '0; charge_state <= '0;
			limits_result <= '0; health_result <= '0;
			capacity_total <= '0; capacity_remaining <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					if (take) begin
						tally_q <= tally_q + 1'b1;
						vsum_q <= vsum_q + {3'd0, lf_q[15:0]};
						if (lf_q[15:0] > vmax_q) vmax_q <= lf_q[15:0];
						if (lf_q[15:0] < vmin_q) vmin_q <= lf_q[15:0];
						isum_q <= isum_q + {{3{lf_q[31]}}, lf_q[31:16]};
						socsum_q <= socsum_q + {3'd0, prod_q};
						capw_q <= capw_q + {3'd0, ef_q[31:0]};
						capt_q <= capt_q + ef_q[31:0];
						capr_q <= capr_q + ef_q[63:32];
						if (mf_q[15:0] == 16'd0) chz_q <= 1'b1;
						if (mf_q[15:0] < chmin_q) chmin_q <= mf_q[15:0];
						if (mf_q[31:16] == 16'd0) dsz_q <= 1'b1;
						if (mf_q[31:16] < dsmin_q) dsmin_q <= mf_q[31:16];
						if (mf_q[47:32] > cellh_q) cellh_q <= mf_q[47:32];
						if (mf_q[63:48] < celll_q) celll_q <= mf_q[63:48];
						if ($signed(hf_q[15:0]) > temph_q) temph_q <= hf_q[15:0];
						if ($signed(hf_q[31:16]) < templ_q) templ_q <= hf_q[31:16];
						if (hf_q[47:32] < soh_q) soh_q <= hf_q[47:32];
						if (status_rank(lf_q[55:48], codes_q) > status_rank(worst_q, codes_q))
							worst_q <= lf_q[55:48];
						bal_q <= bal_q | hf_q[55:48];
					end
					// the divider is started from ST_DIVV, after the sums have updated
					if (last_q) begin
						state_q <= ST_DIVV;
						div_wait_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIVV: begin
					div_wait_q <= 1'b0;
					if (div_done) begin
						voltage_average <= div_quo[15:0];
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: if (div_done) begin
					charge_state <= (capw_q == '0) ? 16'd0 : div_quo[15:0];
					state_q <= ST_LIMC;
				end
				ST_LIMC: state_q <= ST_LIMD;
				ST_LIMD: begin
					limits_result[15:0] <= chz_q ? 16'd0 : prod_q[15:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done <= 1'b1;
					if (tally_q == '0) begin
						alive_count <= '0; voltage_average <= '0; voltage_highest <= '0;
						voltage_lowest <= '0; current_total <= '0; charge_state <= '0;
						limits_result <= '0; health_result <= '0;
						capacity_total <= '0; capacity_remaining <= '0;
					end else begin
						alive_count <= 4'(tally_q);
						voltage_highest <= vmax_q;
						voltage_lowest <= vmin_q;
						current_total <= isum_q;
						limits_result[31:16] <= dsz_q ? 16'd0 : prod_q[15:0];
						limits_result[63:32] <= {celll_q, cellh_q};
						health_result <= {worst_q, bal_q, soh_q, templ_q, temph_q};
						capacity_total <= capt_q;
						capacity_remaining <= capr_q;
					end
					tally_q <= '0; vsum_q <= '0; vmax_q <= '0; vmin_q <= '1;
					isum_q <= '0; socsum_q <= '0; capw_q <= '0; capt_q <= '0; capr_q <= '0;
					chmin_q <= '1; dsmin_q <= '1; chz_q <= 1'b0; dsz_q <= 1'b0;
					cellh_q <= '0; celll_q <= '1; temph_q <= 16'sh8000; templ_q <= 16'sh7fff;
					soh_q <= '1; worst_q <= codes_q.active; bal_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
